### src/eqz_pkg.sv
// Shared types, constants and helpers for the ZYX Euler to quaternion block.
// Used by every module under src; depends on nothing else.
package eqz_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int QUAT_WIDTH   = 16;
    localparam int NUM_AXES     = 3;
    localparam int CORDIC_STEPS = 30;
    localparam int HALF_W       = 34;
    localparam int CS_W         = 33;
    localparam int MUL_W        = 2 * CS_W;
    localparam int SUM_W        = 64;
    localparam int ANGLE_SHIFT  = 29 - (ANGLE_WIDTH - 4);
    localparam int OUT_SHIFT    = 60 - (QUAT_WIDTH - 2);
    localparam int OUT_VW       = SUM_W - OUT_SHIFT;

    localparam logic signed [HALF_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [HALF_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CS_W-1:0]   GAIN_Q30    = 33'sh026DD3B6A;
    localparam logic signed [OUT_VW-1:0] QUAT_LIM    = OUT_VW'(1) <<< (QUAT_WIDTH - 2);

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
    } t_angles;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
        logic signed [QUAT_WIDTH-1:0] quat_w;
    } t_quat;

    // lane 0 yaw, lane 1 pitch, lane 2 roll
    typedef struct packed {
        logic [NUM_AXES-1:0][HALF_W-1:0] z;
        logic [NUM_AXES-1:0]             neg;
    } t_fold_item;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

    function automatic logic signed [HALF_W-1:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000007;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return $signed({{(HALF_W-32){1'b0}}, v});
    endfunction

    function automatic logic signed [MUL_W-1:0] mul_cs(input logic signed [CS_W-1:0] a,
                                                        input logic signed [CS_W-1:0] b);
        logic signed [MUL_W-1:0] ea;
        logic signed [MUL_W-1:0] eb;
        ea = MUL_W'(a);
        eb = MUL_W'(b);
        return ea * eb;
    endfunction

endpackage

### src/eqz_front.sv
// Input stage: registers one angle word, halves it into Q30 and folds it
// into [-pi/2, pi/2]. Depends on eqz_pkg.
module eqz_front import eqz_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_angles    i_data,
    output logic       o_full,
    input  logic       i_q_ready,
    output logic       o_q_valid,
    output t_fold_item o_q_item
);
    logic       r_vld;
    logic       n_vld;
    t_fold_item r_item;
    t_fold_item n_item;
    logic signed [ANGLE_WIDTH-1:0] w_ang [0:NUM_AXES-1];

    assign w_ang[0] = i_data.yaw_angle;
    assign w_ang[1] = i_data.pitch_angle;
    assign w_ang[2] = i_data.roll_angle;

    always_comb begin
        logic signed [HALF_W-1:0] h;
        for (int l = 0; l < NUM_AXES; l++) begin
            h = HALF_W'(w_ang[l]) <<< ANGLE_SHIFT;
            n_item.neg[l] = 1'b0;
            n_item.z[l]   = h;
            if (h > HALF_PI_Q30) begin
                n_item.z[l]   = h - PI_Q30;
                n_item.neg[l] = 1'b1;
            end else if (h < -HALF_PI_Q30) begin
                n_item.z[l]   = h + PI_Q30;
                n_item.neg[l] = 1'b1;
            end
        end
    end

    assign o_full    = r_vld && !i_q_ready;
    assign o_q_valid = r_vld;
    assign o_q_item  = r_item;

    // hold the word while the queue is full
    always_comb begin
        n_vld = r_vld;
        if (!o_full) n_vld = i_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= n_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!o_full && i_push) r_item <= n_item;
    end
endmodule

### src/eqz_queue.sv
// Four-word queue of folded half angles between front and back.
// Depends on eqz_pkg.
module eqz_queue import eqz_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_fold_item i_item,
    output t_hs        o_in_hs,
    input  logic       i_pop,
    output t_fold_item o_item,
    output t_hs        o_out_hs
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_fold_item      r_mem [0:DEPTH-1];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [PW:0]     r_cnt;
    logic            w_wen;
    logic            w_ren;

    assign o_in_hs.ready  = (r_cnt != (PW+1)'(DEPTH));
    assign o_in_hs.valid  = i_push;
    assign o_out_hs.valid = (r_cnt != '0);
    assign o_out_hs.ready = i_pop;
    assign w_wen = i_push && o_in_hs.ready;
    assign w_ren = i_pop && o_out_hs.valid;
    assign o_item = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wen) r_wr <= r_wr + 1'b1;
            if (w_ren) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_wen) - (PW+1)'(w_ren);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) r_mem[r_wr] <= i_item;
    end
endmodule

### src/eqz_back.sv
// Back end: three-lane CORDIC pipeline, quaternion product stages and a
// two-word result queue. Depends on eqz_pkg.
module eqz_back import eqz_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_fold_item i_q_item,
    output logic       o_q_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output t_quat      o_result
);
    localparam int NS = CORDIC_STEPS;

    logic signed [CS_W-1:0]   r_x  [0:NS][0:NUM_AXES-1];
    logic signed [CS_W-1:0]   r_y  [0:NS][0:NUM_AXES-1];
    logic signed [HALF_W-1:0] r_z  [0:NS][0:NUM_AXES-1];
    logic                     r_ng [0:NS][0:NUM_AXES-1];
    logic                     r_cv [0:NS];
    logic signed [CS_W-1:0]   r_c  [0:NUM_AXES-1];
    logic signed [CS_W-1:0]   r_s  [0:NUM_AXES-1];
    logic                     r_sv;
    logic signed [MUL_W-1:0]  r_m1 [0:3];
    logic signed [CS_W-1:0]   r_cr;
    logic signed [CS_W-1:0]   r_sr;
    logic                     r_v1;
    logic signed [SUM_W-1:0]  r_m2 [0:7];
    logic                     r_v2;

    t_quat      r_o [0:1];
    logic       r_owr;
    logic       r_ord;
    logic [1:0] r_ocnt;
    logic       w_en;
    logic       w_push;
    logic       w_opop;
    logic signed [CS_W-1:0] w_ab [0:3];
    t_quat      w_q;

    // advance whenever the result queue has room or is drained this cycle
    assign w_en    = (r_ocnt != 2'd2) || i_pop;
    assign o_q_pop = w_en && i_q_valid;
    assign w_push  = w_en && r_v2;
    assign w_opop  = i_pop && (r_ocnt != 2'd0);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_result = r_o[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) r_cv[k] <= 1'b0;
            r_sv <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_cv[0] <= i_q_valid;
            for (int k = 0; k < NS; k++) r_cv[k+1] <= r_cv[k];
            r_sv <= r_cv[NS];
            r_v1 <= r_sv;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < NUM_AXES; l++) begin
                r_x[0][l]  <= GAIN_Q30;
                r_y[0][l]  <= '0;
                r_z[0][l]  <= $signed(i_q_item.z[l]);
                r_ng[0][l] <= i_q_item.neg[l];
            end
            for (int k = 0; k < NS; k++) begin
                for (int l = 0; l < NUM_AXES; l++) begin
                    r_ng[k+1][l] <= r_ng[k][l];
                    if (!r_z[k][l][HALF_W-1]) begin
                        r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] - atan_q30(k);
                    end else begin
                        r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] + atan_q30(k);
                    end
                end
            end
            for (int l = 0; l < NUM_AXES; l++) begin
                r_c[l] <= r_ng[NS][l] ? -r_x[NS][l] : r_x[NS][l];
                r_s[l] <= r_ng[NS][l] ? -r_y[NS][l] : r_y[NS][l];
            end
            // yaw by pitch pairs
            r_m1[0] <= mul_cs(r_c[0], r_c[1]);
            r_m1[1] <= mul_cs(r_s[0], r_s[1]);
            r_m1[2] <= mul_cs(r_c[0], r_s[1]);
            r_m1[3] <= mul_cs(r_s[0], r_c[1]);
            r_cr    <= r_c[2];
            r_sr    <= r_s[2];
            r_m2[0] <= SUM_W'(mul_cs(w_ab[0], r_sr));
            r_m2[1] <= SUM_W'(mul_cs(w_ab[1], r_cr));
            r_m2[2] <= SUM_W'(mul_cs(w_ab[2], r_cr));
            r_m2[3] <= SUM_W'(mul_cs(w_ab[3], r_sr));
            r_m2[4] <= SUM_W'(mul_cs(w_ab[3], r_cr));
            r_m2[5] <= SUM_W'(mul_cs(w_ab[2], r_sr));
            r_m2[6] <= SUM_W'(mul_cs(w_ab[0], r_cr));
            r_m2[7] <= SUM_W'(mul_cs(w_ab[1], r_sr));
        end
    end

    // round the Q60 pair products back to Q30
    always_comb begin
        logic signed [MUL_W-1:0] t;
        for (int j = 0; j < 4; j++) begin
            t = r_m1[j] + (MUL_W'(1) <<< 29);
            w_ab[j] = t[CS_W+29:30];
        end
    end

    function automatic logic signed [QUAT_WIDTH-1:0] quat_round(
        input logic signed [SUM_W-1:0] q);
        logic signed [SUM_W-1:0]  t;
        logic signed [OUT_VW-1:0] v;
        t = q + (SUM_W'(1) <<< (OUT_SHIFT - 1));
        v = t[SUM_W-1:OUT_SHIFT];
        if (v > QUAT_LIM)       v = QUAT_LIM;
        else if (v < -QUAT_LIM) v = -QUAT_LIM;
        return v[QUAT_WIDTH-1:0];
    endfunction

    always_comb begin
        w_q.quat_x = quat_round(r_m2[0] - r_m2[1]);
        w_q.quat_y = quat_round(r_m2[2] + r_m2[3]);
        w_q.quat_z = quat_round(r_m2[4] - r_m2[5]);
        w_q.quat_w = quat_round(r_m2[6] + r_m2[7]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_push) r_owr <= ~r_owr;
            if (w_opop) r_ord <= ~r_ord;
            r_ocnt <= r_ocnt + 2'(w_push) - 2'(w_opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_o[r_owr] <= w_q;
    end
endmodule

### src/euler_zyx_to_quaternion_top.sv
// Top level of the ZYX Euler to quaternion converter.
// Instantiates eqz_front, eqz_queue and eqz_back; depends on eqz_pkg.
//
// Usage:
//   Input channel: drive i_angles (yaw, pitch, roll, signed Q4.12 radians)
//   and raise i_push; the word is taken on a clock edge where o_full is low.
//   Result channel: while o_empty is low, o_quat holds the oldest quaternion
//   (x, y, z, w in signed Q1.14); raise i_pop to take it.
//   Throughput: one word per cycle, no bubbles, unless the result slots fill.
//   Path: from accept to o_empty falling on an idle block, the input
//   register loads at the accepting edge, then one queue slot,
//   31 CORDIC stages (30 iterations plus the load), one sign stage, two
//   multiply stages and the result register.
//   Stall: with i_pop low the back end freezes once its two result slots
//   fill; the four-word middle queue and input register then fill and
//   o_full rises. Nothing is dropped.
//   Reset: synchronous, active low; all queues empty, pipeline drained.
module euler_zyx_to_quaternion_top import eqz_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_angles i_angles,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_quat   o_quat
);
    logic       w_f_valid;
    t_fold_item w_f_item;
    t_hs        w_qin_hs;
    t_hs        w_qout_hs;
    t_fold_item w_q_item;
    logic       w_q_pop;

    eqz_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_data    (i_angles),
        .o_full    (o_full),
        .i_q_ready (w_qin_hs.ready),
        .o_q_valid (w_f_valid),
        .o_q_item  (w_f_item)
    );

    eqz_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_f_valid),
        .i_item   (w_f_item),
        .o_in_hs  (w_qin_hs),
        .i_pop    (w_q_pop),
        .o_item   (w_q_item),
        .o_out_hs (w_qout_hs)
    );

    eqz_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qout_hs.valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_quat)
    );

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_qout_hs.valid)
        else $error("back end took from an empty queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("channels not cleared by reset");

    a_full_holds_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (w_f_valid && !w_qin_hs.ready))
        else $error("full raised with room in the queue");
endmodule

### test/euler_zyx_to_quaternion_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for euler_zyx_to_quaternion_top: a scoreboard class predicts each
// quaternion from the accepted angles; plain tasks drive push/pop. Depends on eqz_pkg.
module euler_zyx_to_quaternion_top_test;
    import eqz_pkg::*;

    localparam int  RAND_WORDS = 1050;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint GAIN = 64'sh26DD3B6A;
    localparam longint HPI  = 64'sd1686629713;
    localparam longint PI   = 64'sd3373259426;

    class quat_scoreboard;
        t_quat  pending_q[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        static function longint atan_tab(int i);
            longint t[30] = '{
                64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
                64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};
            return t[i];
        endfunction

        // half-angle cosine and sine in Q30
        static function void half_trig(logic signed [ANGLE_WIDTH-1:0] ang,
                                       output longint c, output longint s);
            longint z, x, y, dx, dy;
            bit     neg;
            z = longint'(ang) * (64'sd1 <<< (29 - (ANGLE_WIDTH - 4)));
            neg = 0;
            x = GAIN;
            y = 0;
            if (z > HPI) begin
                z -= PI;
                neg = 1;
            end else if (z < -HPI) begin
                z += PI;
                neg = 1;
            end
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab(i);
                end else begin
                    x += dx; y -= dy; z += atan_tab(i);
                end
            end
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        static function longint triple(longint a, longint b, longint c);
            longint ab;
            ab = (a * b + (64'sd1 <<< 29)) >>> 30;
            return ab * c;
        endfunction

        static function logic [QUAT_WIDTH-1:0] to_q14(longint q60);
            longint v, lim;
            lim = 64'sd1 <<< (QUAT_WIDTH - 2);
            v = (q60 + (64'sd1 <<< (60 - (QUAT_WIDTH - 2) - 1))) >>> (60 - (QUAT_WIDTH - 2));
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            return v[QUAT_WIDTH-1:0];
        endfunction

        function void note_angles(t_angles a);
            longint cz, sz, cy, sy, cx, sx;
            t_quat  q;
            half_trig(a.yaw_angle, cz, sz);
            half_trig(a.pitch_angle, cy, sy);
            half_trig(a.roll_angle, cx, sx);
            q.quat_x = to_q14(triple(cz, cy, sx) - triple(sz, sy, cx));
            q.quat_y = to_q14(triple(cz, sy, cx) + triple(sz, cy, sx));
            q.quat_z = to_q14(triple(sz, cy, cx) - triple(cz, sy, sx));
            q.quat_w = to_q14(triple(cz, cy, cx) + triple(sz, sy, sx));
            pending_q.push_back(q);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_quat(t_quat got);
            t_quat want;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
                return;
            end
            want = pending_q.pop_front();
            if (got.quat_x !== want.quat_x) report_mismatch("quat_x", got.quat_x, want.quat_x);
            if (got.quat_y !== want.quat_y) report_mismatch("quat_y", got.quat_y, want.quat_y);
            if (got.quat_z !== want.quat_z) report_mismatch("quat_z", got.quat_z, want.quat_z);
            if (got.quat_w !== want.quat_w) report_mismatch("quat_w", got.quat_w, want.quat_w);
        endtask
    endclass

    logic    i_clk = 0;
    logic    i_rst_n = 0;
    logic    i_push = 0;
    t_angles i_angles = '0;
    logic    o_full;
    logic    i_pop = 0;
    logic    o_empty;
    t_quat   o_quat;

    quat_scoreboard sb = new();
    t_angles stim_q[$];
    int      phase = 0;
    bit      send_done = 0;
    longint  cyc = 0;

    euler_zyx_to_quaternion_top i_dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
        logic [ANGLE_WIDTH-1:0] edges[8] = '{16'h8000, 16'h7FFF, 16'd12867, 16'd12868,
                                             -16'sd12867, -16'sd12868, 16'h0000, 16'hFFFF};
        if ($urandom_range(0, 9) == 0) return edges[$urandom_range(0, 7)];
        return ANGLE_WIDTH'($urandom());
    endfunction

    task build_stimulus();
        logic [ANGLE_WIDTH-1:0] dv[12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                                           16'd12867, 16'd12868, -16'sd12867, -16'sd12868,
                                           16'h5555, 16'hAAAA, 16'd6434};
        t_angles a;
        foreach (dv[i]) begin
            a.yaw_angle = dv[i];
            a.pitch_angle = dv[(i + 4) % 12];
            a.roll_angle = dv[(i + 8) % 12];
            stim_q.push_back(a);
        end
        for (int i = 0; i < 8; i++) begin
            a = '0;
            if (i % 3 == 0) a.yaw_angle = dv[i + 1];
            if (i % 3 == 1) a.pitch_angle = dv[i + 1];
            if (i % 3 == 2) a.roll_angle = dv[i + 1];
            stim_q.push_back(a);
        end
        for (int i = 0; i < RAND_WORDS; i++) begin
            a.yaw_angle = pick_angle();
            a.pitch_angle = pick_angle();
            a.roll_angle = pick_angle();
            stim_q.push_back(a);
        end
    endtask

    // phase 0 no idling, 1 sender idles, 2 receiver stalls, 3 both
    task drive_angles();
        int idx, next_phase, idle_pct;
        idx = 0;
        while (idx < stim_q.size()) begin
            next_phase = (idx * 4) / stim_q.size();
            if (next_phase != phase) begin
                // drain fully before the receiver-stall phase
                if (next_phase == 2) begin
                    @(negedge i_clk) i_push <= 0;
                    wait (sb.pending_q.size() == 0);
                end
                phase = next_phase;
            end
            idle_pct = (phase == 1) ? 65 : (phase == 3) ? 37 : 0;
            @(negedge i_clk);
            i_push <= ($urandom_range(0, 99) >= idle_pct);
            i_angles <= stim_q[idx];
            @(posedge i_clk);
            if (i_push && !o_full) begin
                sb.note_angles(stim_q[idx]);
                idx++;
            end
        end
        @(negedge i_clk) i_push <= 0;
        send_done = 1;
    endtask

    task drain_quats();
        int  stall_pct, hold;
        bit  held;
        held = 0;
        hold = 0;
        forever begin
            stall_pct = (phase == 2) ? 65 : (phase == 3) ? 37 : 0;
            // hold off long enough for the block to fill and raise full
            if (phase == 2 && !held) begin
                held = 1;
                hold = 300;
            end
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                i_pop <= 0;
            end else begin
                i_pop <= ($urandom_range(0, 99) >= stall_pct);
            end
            @(posedge i_clk);
            if (i_pop && !o_empty) sb.check_quat(o_quat);
        end
    endtask

    initial begin
        build_stimulus();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;
        fork
            drain_quats();
        join_none
        drive_angles();
        wait (send_done && sb.pending_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (sb.pending_q.size() != 0) sb.report_mismatch("words left over", 0, 0);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
src/eqz_pkg.sv
src/eqz_front.sv
src/eqz_queue.sv
src/eqz_back.sv
src/euler_zyx_to_quaternion_top.sv
test/euler_zyx_to_quaternion_top_test.sv
